@@ hdl/rhb_pkg.sv @@
package rhb_pkg;

  // Default sizes of the history and of the stored handles.
  localparam int unsigned HistoryDepthDef = 16;
  localparam int unsigned HandleBitsDef   = 10;

  // At most this many entries are released by one tick.
  localparam int unsigned MaxResults  = 16;
  localparam int unsigned ResCntBits  = $clog2(MaxResults + 1);

  // Fixed field widths of the request and result payloads.
  localparam int unsigned KeyBits       = 8;
  localparam int unsigned HandleOutBits = 10;
  localparam int unsigned SecondsBits   = 32;
  localparam int unsigned RetentionBits = 8;
  localparam int unsigned LingerBits    = 4;
  localparam int unsigned CfgDataBits   = 8;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_LOOKUP  = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_RETENTION = 1'b0,
    CFG_LINGER    = 1'b1
  } cfg_reg_e;

  // Source of the handle field of a result.
  typedef enum logic [1:0] {
    HSEL_ZERO = 2'd0,
    HSEL_READ = 2'd1,
    HSEL_PEND = 2'd2
  } hsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_LK_RD,
    ST_LK_CMP,
    ST_TK_RD,
    ST_TK_CMP
  } state_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [KeyBits-1:0]       frag_index;
    logic [KeyBits-1:0]       seq_number;
    logic [HandleOutBits-1:0] buffer_handle;
  } rhb_req_t;

  typedef struct packed {
    logic [1:0]               reply_kind;
    logic                     hit;
    logic [HandleOutBits-1:0] handle_out;
    logic                     last;
  } rhb_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch_req;
    logic  sec_inc;
    logic  scan_init;
    logic  scan_next;
    logic  rd_head;
    logic  push_wr;
    logic  dl_wr;
    logic  pop;
    logic  emit;
    kind_e kind;
    logic  hit;
    hsel_e hsel;
    logic  last;
  } rhb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_end;
    logic key_match;
    logic expired;
    logic quota;
    logic pend;
  } rhb_status_t;

endpackage

@@ hdl/rhb_datapath.sv @@
module rhb_datapath import rhb_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef,
  parameter int unsigned HANDLE_BITS   = HandleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rhb_req_t               req_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  rhb_cmd_t               cmd_i,
  output rhb_status_t            status_o,
  output logic                   result_valid_o,
  output rhb_rsp_t               result_o
);

  localparam int unsigned PtrBits = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntBits = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr   = PtrBits'(HISTORY_DEPTH - 1);
  localparam logic [CntBits-1:0] FullCount = CntBits'(HISTORY_DEPTH);

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrBits'(1);
  endfunction

  // History storage; contents are undefined until written.
  logic [KeyBits-1:0]     entry_frag_q     [HISTORY_DEPTH];
  logic [KeyBits-1:0]     entry_seq_q      [HISTORY_DEPTH];
  logic [HANDLE_BITS-1:0] entry_handle_q   [HISTORY_DEPTH];
  logic [SecondsBits-1:0] entry_deadline_q [HISTORY_DEPTH];

  logic [KeyBits-1:0]     rd_frag_q, rd_seq_q;
  logic [HANDLE_BITS-1:0] rd_handle_q;
  logic [SecondsBits-1:0] rd_deadline_q;

  logic [RetentionBits-1:0] retention_q, retention_d;
  logic [LingerBits-1:0]    linger_q, linger_d;
  logic [SecondsBits-1:0]   seconds_q, seconds_d;
  logic [PtrBits-1:0]       head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CntBits-1:0]       count_q, count_d, idx_q, idx_d;
  logic [ResCntBits-1:0]    n_q, n_d;
  logic                     rsp_valid_q, rsp_valid_d;

  rhb_req_t               req_q;
  logic [HANDLE_BITS-1:0] pend_q;
  rhb_rsp_t               rsp_q, rsp_d;

  logic [PtrBits-1:0]     rd_addr, wr_addr;
  logic                   dl_we;
  logic [SecondsBits-1:0] wr_deadline;
  logic [31:0]            push_handle_ext;
  logic [31:0]            out_handle_ext;

  assign push_handle_ext = 32'(req_q.buffer_handle);
  assign rd_addr         = cmd_i.rd_head ? head_q : ptr_q;
  assign wr_addr         = cmd_i.push_wr ? tail_q : ptr_q;
  assign dl_we           = cmd_i.push_wr | cmd_i.dl_wr;
  assign wr_deadline     = cmd_i.push_wr ? seconds_q + SecondsBits'(retention_q)
                                         : rd_deadline_q + SecondsBits'(linger_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      entry_frag_q[tail_q]   <= req_q.frag_index;
      entry_seq_q[tail_q]    <= req_q.seq_number;
      entry_handle_q[tail_q] <= push_handle_ext[HANDLE_BITS-1:0];
    end
    if (dl_we) begin
      entry_deadline_q[wr_addr] <= wr_deadline;
    end
    rd_frag_q     <= entry_frag_q[rd_addr];
    rd_seq_q      <= entry_seq_q[rd_addr];
    rd_handle_q   <= entry_handle_q[rd_addr];
    rd_deadline_q <= entry_deadline_q[rd_addr];
  end

  assign status_o.full      = (count_q == FullCount);
  assign status_o.empty     = (count_q == '0);
  assign status_o.scan_end  = (idx_q == count_q);
  assign status_o.key_match = (rd_frag_q == req_q.frag_index) &&
                              (rd_seq_q == req_q.seq_number);
  assign status_o.expired   = (rd_deadline_q <= seconds_q);
  assign status_o.quota     = (n_q == ResCntBits'(MaxResults));
  assign status_o.pend      = (n_q != '0);

  always_comb begin
    retention_d = retention_q;
    linger_d    = linger_q;
    seconds_d   = seconds_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    rsp_valid_d = cmd_i.emit;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RETENTION: retention_d = cfg_wdata_i[RetentionBits-1:0];
        CFG_LINGER:    linger_d    = cfg_wdata_i[LingerBits-1:0];
      endcase
    end
    if (cmd_i.sec_inc) begin
      seconds_d = seconds_q + SecondsBits'(1);
    end
    if (cmd_i.scan_init) begin
      ptr_d = head_q;
      idx_d = '0;
      n_d   = '0;
    end
    if (cmd_i.scan_next) begin
      ptr_d = next_ptr(ptr_q);
      idx_d = idx_q + CntBits'(1);
    end
    if (cmd_i.push_wr) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + CntBits'(1);
    end
    if (cmd_i.pop) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - CntBits'(1);
      n_d     = n_q + ResCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retention_q <= RetentionBits'(2);
      linger_q    <= LingerBits'(1);
      seconds_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ptr_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      retention_q <= retention_d;
      linger_q    <= linger_d;
      seconds_q   <= seconds_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    out_handle_ext = '0;
    case (cmd_i.hsel)
      HSEL_READ: out_handle_ext = 32'(rd_handle_q);
      HSEL_PEND: out_handle_ext = 32'(pend_q);
      default:   out_handle_ext = '0;
    endcase
    rsp_d.reply_kind = cmd_i.kind;
    rsp_d.hit        = cmd_i.hit;
    rsp_d.handle_out = out_handle_ext[HandleOutBits-1:0];
    rsp_d.last       = cmd_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
    end
    if (cmd_i.pop) begin
      pend_q <= rd_handle_q;
    end
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

endmodule

@@ hdl/rhb_ctrl.sv @@
module rhb_ctrl import rhb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  command_i,
  input  rhb_status_t status_i,
  output rhb_cmd_t    cmd_o,
  output logic        busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_PUSH:   state_d = ST_PUSH;
            CMD_LOOKUP: state_d = ST_LK_RD;
            CMD_TICK:   state_d = ST_TK_RD;
            CMD_NONE:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:   state_d = ST_IDLE;
      ST_LK_RD:  state_d = status_i.scan_end ? ST_IDLE : ST_LK_CMP;
      ST_LK_CMP: state_d = status_i.key_match ? ST_IDLE : ST_LK_RD;
      ST_TK_RD:  state_d = (status_i.empty || status_i.quota) ? ST_IDLE : ST_TK_CMP;
      ST_TK_CMP: state_d = status_i.expired ? ST_TK_RD : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch_req = 1'b1;
          cmd_o.scan_init = 1'b1;
          cmd_o.sec_inc   = (command_i == CMD_TICK);
        end
      end
      ST_PUSH: begin
        cmd_o.push_wr = !status_i.full;
        cmd_o.emit    = 1'b1;
        cmd_o.kind    = KIND_ACK;
        cmd_o.hit     = !status_i.full;
        cmd_o.hsel    = HSEL_ZERO;
        cmd_o.last    = 1'b1;
      end
      ST_LK_RD: begin
        if (status_i.scan_end) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_LOOKUP;
          cmd_o.hsel = HSEL_ZERO;
          cmd_o.last = 1'b1;
        end
      end
      ST_LK_CMP: begin
        if (status_i.key_match) begin
          cmd_o.dl_wr = 1'b1;
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = KIND_LOOKUP;
          cmd_o.hit   = 1'b1;
          cmd_o.hsel  = HSEL_READ;
          cmd_o.last  = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_TK_RD: begin
        cmd_o.rd_head = 1'b1;
        if ((status_i.empty || status_i.quota) && status_i.pend) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_RELEASE;
          cmd_o.hit  = 1'b1;
          cmd_o.hsel = HSEL_PEND;
          cmd_o.last = 1'b1;
        end
      end
      ST_TK_CMP: begin
        // A released handle is held back an entry so that its last flag is known.
        cmd_o.pop  = status_i.expired;
        cmd_o.emit = status_i.pend;
        cmd_o.kind = KIND_RELEASE;
        cmd_o.hit  = 1'b1;
        cmd_o.hsel = HSEL_PEND;
        cmd_o.last = !status_i.expired;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/retransmit_history_buffer.sv @@
// A push ends with its acknowledge; a lookup walks the history from the head, one read per
// entry, and ends at the first hit or with a miss once every entry is checked. A tick
// releases expired entries from the head, at most 16 of them, with one read per entry.
// A new request is taken once busy_o is low; results are strobed and cannot be stalled.
// Reset is asynchronous: counters and pointers clear, configuration registers take defaults;
// history contents stay undefined and need no clearing pass, so requests follow reset at once.
module retransmit_history_buffer import rhb_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef,
  parameter int unsigned HANDLE_BITS   = HandleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  rhb_req_t               req_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output rhb_rsp_t               result_o
);

  // The controller sequences each request: a push writes the tail entry, a lookup walks
  // the history from the head one entry at a time, and a tick pops expired entries from
  // the head. The datapath owns the history memory, the pointers, the seconds counter,
  // the configuration registers and the registered result.
  rhb_cmd_t    cmd;
  rhb_status_t status;

  rhb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (req_i.command),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  rhb_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTH
  // Every result comes out of work done while the block was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a request in progress");

  // The final result of a request ends it; earlier ones leave the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy_o)
    else $error("block still busy after the final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("request ended without a final result");

  // A release never leaves the history tail behind the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.empty)
    else $error("release from an empty history");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rhb_pkg::*;

  // History geometry of the instance under test.
  localparam int unsigned Depth      = HistoryDepthDef;
  localparam int unsigned CycleLimit = 400_000;
  // Extra cycles after the last result before the block is treated as idle.
  // A tick that releases nothing or an ignored command gives no strobe of its own.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseRequests = 80;
  localparam int unsigned NumPhases     = 5;

  // Results that can be read straight off the command, with no history involved.
  localparam rhb_rsp_t ACKED   = '{reply_kind: KIND_ACK, hit: 1'b1, handle_out: '0, last: 1'b1};
  localparam rhb_rsp_t REFUSED = '{reply_kind: KIND_ACK, hit: 1'b0, handle_out: '0, last: 1'b1};
  localparam rhb_rsp_t MISSED  = '{reply_kind: KIND_LOOKUP, hit: 1'b0, handle_out: '0, last: 1'b1};
  localparam rhb_rsp_t UNTYPED = '0;

  typedef struct {
    rhb_req_t req;
    bit       typed;
    rhb_rsp_t want;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  rhb_req_t               req_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_addr_i = 1'b0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   result_valid_o;
  rhb_rsp_t               result_o;

  retransmit_history_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_i         (req_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the history: the same FIFO of fragments, kept in step with every
  // accepted request, together with the two configuration registers.
  // ---------------------------------------------------------------------------
  logic [RetentionBits-1:0] retention_sec = 8'd2;
  logic [LingerBits-1:0]    linger_sec = 4'd1;
  logic [SecondsBits-1:0]   now_sec = '0;
  logic [KeyBits-1:0]       hist_frag [Depth];
  logic [KeyBits-1:0]       hist_seq [Depth];
  logic [HandleOutBits-1:0] hist_handle [Depth];
  logic [SecondsBits-1:0]   hist_deadline [Depth];
  logic [3:0]               hist_head = '0;
  logic [3:0]               hist_tail = '0;
  int unsigned              hist_held = 0;

  // Results that the most recent request gives, and all results still owed by the block.
  rhb_rsp_t fresh_replies[$];
  rhb_rsp_t owed_replies[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  int unsigned released = 0;
  int unsigned refused = 0;
  int unsigned found = 0;
  int unsigned replies_checked = 0;
  int unsigned settings_used = 1;

  function automatic rhb_rsp_t reply(kind_e kind, logic hit, logic [HandleOutBits-1:0] handle,
                                     logic last);
    rhb_rsp_t r;
    r.reply_kind = kind;
    r.hit        = hit;
    r.handle_out = handle;
    r.last       = last;
    return r;
  endfunction

  // Works out what one accepted request returns and updates the shadow history.
  function automatic void forecast_replies(rhb_req_t r);
    logic [3:0]  p;
    int unsigned n;
    bit          hit_seen;
    fresh_replies.delete();
    case (cmd_e'(r.command))
      CMD_PUSH: begin
        if (hist_held >= Depth) begin
          fresh_replies.push_back(reply(KIND_ACK, 1'b0, '0, 1'b1));
        end else begin
          hist_frag[hist_tail]     = r.frag_index;
          hist_seq[hist_tail]      = r.seq_number;
          hist_handle[hist_tail]   = r.buffer_handle;
          hist_deadline[hist_tail] = now_sec + SecondsBits'(retention_sec);
          hist_tail = hist_tail + 4'd1;
          hist_held++;
          fresh_replies.push_back(reply(KIND_ACK, 1'b1, '0, 1'b1));
        end
      end
      CMD_LOOKUP: begin
        // The oldest matching entry wins, so the scan stops at the first hit.
        p = hist_head;
        hit_seen = 1'b0;
        for (int unsigned i = 0; i < hist_held; i++) begin
          if (!hit_seen && hist_frag[p] == r.frag_index && hist_seq[p] == r.seq_number) begin
            hist_deadline[p] = hist_deadline[p] + SecondsBits'(linger_sec);
            fresh_replies.push_back(reply(KIND_LOOKUP, 1'b1, hist_handle[p], 1'b1));
            hit_seen = 1'b1;
          end
          p = p + 4'd1;
        end
        if (!hit_seen) begin
          fresh_replies.push_back(reply(KIND_LOOKUP, 1'b0, '0, 1'b1));
        end
      end
      CMD_TICK: begin
        // Only the head can expire; an entry with a later deadline holds back the rest.
        now_sec = now_sec + 1;
        n = 0;
        while (hist_held > 0 && n < MaxResults && hist_deadline[hist_head] <= now_sec) begin
          fresh_replies.push_back(reply(KIND_RELEASE, 1'b1, hist_handle[hist_head], 1'b0));
          hist_head = hist_head + 4'd1;
          hist_held--;
          n++;
        end
        if (n > 0) begin
          fresh_replies[n-1].last = 1'b1;
        end
      end
      default: begin
        // An undefined command is dropped without a result.
      end
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. On return the
  // clock edge of acceptance is the current time step and start_i is still high.
  task automatic issue(rhb_req_t r, bit typed, rhb_rsp_t want);
    req_i   <= r;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    cmd_seen[r.command]++;
    forecast_replies(r);
    if (typed) begin
      // Rows with a typed result replace the computed one, which is only used to
      // keep the shadow history in step.
      owed_replies.push_back(want);
    end else begin
      foreach (fresh_replies[i]) owed_replies.push_back(fresh_replies[i]);
    end
  endtask

  // Random gap before the next request; the gap goes on while a draw below pct of a hundred comes up.
  task automatic sender_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stops sending until every owed result has come and the block has settled.
  task automatic drain(int unsigned settle);
    start_i <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after its last write.
  task automatic write_register(cfg_reg_e which, logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= which;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (which == CFG_RETENTION) begin
      retention_sec = data[RetentionBits-1:0];
    end else begin
      linger_sec = data[LingerBits-1:0];
    end
  endtask

  // Random request: pushes most often, lookups that usually name a live fragment,
  // ticks, and now and then an undefined command. Keys are often drawn from a
  // tiny range so that duplicate entries appear.
  function automatic rhb_req_t random_request();
    rhb_req_t    r;
    int unsigned roll;
    logic [3:0]  pick;
    roll            = $urandom_range(99);
    r.frag_index    = $urandom_range(1) ? KeyBits'($urandom) : KeyBits'($urandom_range(3));
    r.seq_number    = $urandom_range(1) ? KeyBits'($urandom) : KeyBits'($urandom_range(3));
    r.buffer_handle = HandleOutBits'($urandom);
    if (roll < 45) begin
      r.command = CMD_PUSH;
    end else if (roll < 70) begin
      r.command = CMD_LOOKUP;
      if (hist_held > 0 && $urandom_range(3) != 0) begin
        pick = hist_head + 4'($urandom_range(hist_held - 1));
        r.frag_index = hist_frag[pick];
        r.seq_number = hist_seq[pick];
      end
    end else if (roll < 95) begin
      r.command = CMD_TICK;
    end else begin
      r.command = CMD_NONE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed part. After reset the registers hold a retention of two seconds
  // and a linger of one. The history is filled to the brim, a push is refused,
  // a lookup on a duplicate key must return the older copy and delay it, and
  // that delayed entry then holds back the release of everything behind it.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [25] = '{
    '{'{CMD_LOOKUP, 8'h00, 8'h00, 10'h000}, 1'b1, MISSED},   // lookup on an empty history
    '{'{CMD_TICK,   8'h00, 8'h00, 10'h000}, 1'b0, UNTYPED},  // tick with nothing to release
    '{'{CMD_NONE,   8'hFF, 8'hFF, 10'h3FF}, 1'b0, UNTYPED},  // undefined command is ignored
    '{'{CMD_PUSH,   8'h00, 8'h00, 10'h000}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hFF, 8'hFF, 10'h3FF}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h01, 8'h80, 10'h001}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h80, 8'h01, 10'h200}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h12, 8'h34, 10'h155}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h34, 8'h12, 10'h2AA}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hAA, 8'h55, 10'h0F0}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h55, 8'hAA, 10'h30F}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h7F, 8'hFE, 10'h1FF}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hFE, 8'h7F, 10'h3FE}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h0F, 8'hF0, 10'h100}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hF0, 8'h0F, 10'h0FF}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hC3, 8'h3C, 10'h2C3}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h3C, 8'hC3, 10'h13C}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'h99, 8'h66, 10'h366}, 1'b1, ACKED},
    '{'{CMD_PUSH,   8'hFF, 8'hFF, 10'h001}, 1'b1, ACKED},    // duplicate key, history now full
    '{'{CMD_PUSH,   8'h42, 8'h24, 10'h242}, 1'b1, REFUSED},  // push into a full history
    '{'{CMD_LOOKUP, 8'hFF, 8'h00, 10'h000}, 1'b1, MISSED},   // no such fragment
    '{'{CMD_TICK,   8'h00, 8'h00, 10'h000}, 1'b0, UNTYPED},  // nothing has expired yet
    '{'{CMD_LOOKUP, 8'hFF, 8'hFF, 10'h000}, 1'b0, UNTYPED},  // duplicate: the older copy hits
    '{'{CMD_TICK,   8'h00, 8'h00, 10'h000}, 1'b0, UNTYPED},  // only the oldest entry leaves
    '{'{CMD_TICK,   8'h00, 8'h00, 10'h000}, 1'b0, UNTYPED}   // the remaining fifteen leave
  };

  // Register settings of the random phases: the extremes of both registers, a
  // retention of zero that expires at the very next tick, and ordinary values.
  // The upper nibble of a linger write is random, as only the low bits count.
  logic [RetentionBits-1:0] phase_retention [NumPhases] = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd2};
  logic [LingerBits-1:0]    phase_linger    [NumPhases] = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd7};
  int unsigned              phase_idle      [NumPhases] = '{0, 84, 0, 37, 84};

  initial begin
    rhb_req_t    r;
    int unsigned counted;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      sender_gap(30);
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      // Registers change only while the block is idle.
      drain(SettleCycles);
      write_register(CFG_RETENTION, phase_retention[ph]);
      write_register(CFG_LINGER, {4'($urandom), phase_linger[ph]});
      cfg_we_i <= 1'b0;
      settings_used++;
      counted = 0;
      while (counted < PhaseRequests) begin
        sender_gap(phase_idle[ph]);
        // Now and then hold off until the block has handed back every result.
        if ($urandom_range(49) == 0) begin
          drain(SettleCycles);
        end
        r = random_request();
        issue(r, 1'b0, UNTYPED);
        if (r.command != CMD_NONE) begin
          counted++;
        end
      end
    end

    drain(4 * SettleCycles);
    $display("Covered %0d pushes, %0d lookups, %0d ticks and %0d ignored commands",
             cmd_seen[CMD_PUSH], cmd_seen[CMD_LOOKUP], cmd_seen[CMD_TICK], cmd_seen[CMD_NONE]);
    $display("under %0d register settings; %0d results: %0d releases, %0d refusals, %0d hits.",
             settings_used, replies_checked, released, refused, found);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checking. A result is on the ports for one cycle only and is taken
  // at the edge that closes it; it is compared with the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rhb_rsp_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (owed_replies.size() == 0) begin
        $error("result with none owed: kind %0d hit %0d handle %0d last %0d",
               result_o.reply_kind, result_o.hit, result_o.handle_out, result_o.last);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        replies_checked++;
        if (result_o.reply_kind !== want.reply_kind) begin
          $error("reply_kind: expected %0d, got %0d", want.reply_kind, result_o.reply_kind);
          mismatches++;
        end
        if (result_o.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, result_o.hit);
          mismatches++;
        end
        if (result_o.handle_out !== want.handle_out) begin
          $error("handle_out: expected %0d, got %0d", want.handle_out, result_o.handle_out);
          mismatches++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result_o.last);
          mismatches++;
        end
        if (want.reply_kind == KIND_RELEASE) released++;
        if (want.reply_kind == KIND_ACK && !want.hit) refused++;
        if (want.reply_kind == KIND_LOOKUP && want.hit) found++;
      end
    end
  end

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still owed",
               cycle_count, owed_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule

@@ retransmit_history_buffer.f @@
hdl/rhb_pkg.sv
hdl/rhb_datapath.sv
hdl/rhb_ctrl.sv
hdl/retransmit_history_buffer.sv
verif/testbench.sv
